>>> hdl/ckl_pkg.sv
// Shared types, constants and the keyword table of the C keyword counter.
package ckl_pkg;

    localparam int MAX_WORD_DEF    = 100;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam int KW_NUM       = 13;
    localparam int NUM_KEYWORDS = 13;
    localparam int KW_ACTIVE    = (NUM_KEYWORDS < KW_NUM) ? NUM_KEYWORDS : KW_NUM;
    localparam int KW_IDX_W     = 4;
    localparam int PREFIX_DEPTH = 8;
    localparam int PREFIX_IDX_W = $clog2(PREFIX_DEPTH);
    localparam int REPORT_W     = 32;

    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

    localparam logic REPORT_HIT  = 1'b0;
    localparam logic REPORT_DUMP = 1'b1;

    // Keyword text with the first character in the top byte.
    localparam logic [63:0] KW_TEXT [KW_NUM] = '{
        64'h6175746F_00000000,  // auto
        64'h62726561_6B000000,  // break
        64'h63617365_00000000,  // case
        64'h63686172_00000000,  // char
        64'h636F6E73_74000000,  // const
        64'h636F6E74_696E7565,  // continue
        64'h64656661_756C7400,  // default
        64'h64656669_6E650000,  // define
        64'h69660000_00000000,  // if
        64'h756E7369_676E6564,  // unsigned
        64'h766F6964_00000000,  // void
        64'h766F6C61_74696C65,  // volatile
        64'h7768696C_65000000   // while
    };

    localparam logic [3:0] KW_LEN [KW_NUM] = '{
        4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd6, 4'd2, 4'd8, 4'd4, 4'd8, 4'd5
    };

    typedef enum logic [2:0] {
        M_IDLE  = 3'd0,
        M_WORD  = 3'd1,
        M_QUOTE = 3'd2,
        M_SLASH = 3'd3,
        M_LINE  = 3'd4,
        M_BLOCK = 3'd5,
        M_STAR  = 3'd6
    } t_lex_mode;

    typedef enum logic {
        B_IDLE = 1'b0,
        B_SCAN = 1'b1
    } t_back_state;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       end_of_stream;
    } t_in_item;

    typedef struct packed {
        logic                report_kind;
        logic [KW_IDX_W-1:0] keyword_index;
        logic [REPORT_W-1:0] keyword_count;
        logic                last_of_run;
    } t_result;

    typedef struct packed {
        logic                has_hit;
        logic [KW_IDX_W-1:0] hit_idx;
        logic                dump;
    } t_cmd;

endpackage

>>> hdl/c_keyword_lexer_counter.sv
// Top level of the C keyword counter: lexer front end, command queue and counter back end.
//
// Source bytes enter through a queue-style port: an item is taken at a clock edge with
// push high and full low. Results leave the same way: the oldest result sits on o_result
// while empty is low and is taken at an edge with pop high.
// The lexer takes one byte per cycle while full is low. A hit report passes through the
// command queue and the result register before it appears on o_result. An end-of-stream
// item holds the back end while it takes the command, which also loads the report of a
// pending keyword, and then walks all thirteen counters, reporting each nonzero one. Bytes
// keep flowing meanwhile until the four-entry command queue fills, and then full rises.
// When the receiver stalls, the single result register holds its item, the back end
// waits, and the lexer runs on until the command queue is full.
// A synchronous reset clears the lexer state and all counters at once, with no
// clearing pass; empty is high and full is low after reset.
module c_keyword_lexer_counter #(
    parameter int MAX_WORD    = ckl_pkg::MAX_WORD_DEF,
    parameter int COUNT_WIDTH = ckl_pkg::COUNT_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  ckl_pkg::t_in_item i_in_item,
    output logic              empty,
    input  logic              pop,
    output ckl_pkg::t_result  o_result
);

    logic          accept;
    logic          cmd_push;
    ckl_pkg::t_cmd cmd_in;
    ckl_pkg::t_cmd cmd_head;
    logic          cmd_empty;
    logic          cmd_pop;
    logic          out_valid;

    assign accept = push && !full;
    assign empty  = !out_valid;

    ckl_front #(
        .MAX_WORD (MAX_WORD)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_in_item),
        .o_cmd_valid (cmd_push),
        .o_cmd       (cmd_in)
    );

    ckl_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (full),
        .o_empty (cmd_empty),
        .i_pop   (cmd_pop),
        .o_data  (cmd_head)
    );

    ckl_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!cmd_empty),
        .i_cmd       (cmd_head),
        .o_cmd_pop   (cmd_pop),
        .o_valid     (out_valid),
        .i_pop       (pop),
        .o_result    (o_result)
    );

endmodule

>>> hdl/ckl_front.sv
// Lexer front end: classifies source bytes and issues keyword hit and dump commands.
module ckl_front #(
    parameter int MAX_WORD = ckl_pkg::MAX_WORD_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  ckl_pkg::t_in_item i_item,
    output logic             o_cmd_valid,
    output ckl_pkg::t_cmd    o_cmd
);

    localparam int LEN_W = $clog2(MAX_WORD + 1);

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return is_alpha(c) || (c inside {[8'h30:8'h39], 8'h5F});
    endfunction

    ckl_pkg::t_lex_mode r_mode, n_mode;
    logic               r_dq, n_dq;
    logic               r_esc, n_esc;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [7:0]         r_prefix [ckl_pkg::PREFIX_DEPTH];

    logic                          pf_we;
    logic [ckl_pkg::PREFIX_IDX_W-1:0] pf_idx;
    logic                          do_fresh;
    logic [7:0]                    c;
    logic                          word_go_on;
    logic                          finishing;
    logic [ckl_pkg::KW_NUM-1:0]    kw_hit;
    logic                          any_hit;
    logic [ckl_pkg::KW_IDX_W-1:0]  hit_idx;

    assign c = i_item.source_byte;
    assign word_go_on = is_ident(c) && (r_len < LEN_W'(MAX_WORD));

    always_comb begin
        for (int k = 0; k < ckl_pkg::KW_NUM; k++) begin
            kw_hit[k] = (k < ckl_pkg::KW_ACTIVE) && (r_len == LEN_W'(ckl_pkg::KW_LEN[k]));
            for (int i = 0; i < ckl_pkg::PREFIX_DEPTH; i++) begin
                if ((LEN_W'(i) < r_len) &&
                    (r_prefix[i] != ckl_pkg::KW_TEXT[k][63-8*i -: 8])) begin
                    kw_hit[k] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        any_hit = 1'b0;
        hit_idx = '0;
        for (int k = ckl_pkg::KW_NUM - 1; k >= 0; k--) begin
            if (kw_hit[k]) begin
                any_hit = 1'b1;
                hit_idx = ckl_pkg::KW_IDX_W'(k);
            end
        end
    end

    // Next state of the lexer.
    always_comb begin
        n_mode   = r_mode;
        n_dq     = r_dq;
        n_esc    = r_esc;
        n_len    = r_len;
        pf_we    = 1'b0;
        pf_idx   = r_len[ckl_pkg::PREFIX_IDX_W-1:0];
        do_fresh = 1'b0;
        if (i_accept) begin
            if (i_item.end_of_stream) begin
                n_mode = ckl_pkg::M_IDLE;
                n_esc  = 1'b0;
                n_len  = '0;
            end else begin
                case (r_mode)
                    ckl_pkg::M_WORD: begin
                        if (word_go_on) begin
                            pf_we = (r_len < LEN_W'(ckl_pkg::PREFIX_DEPTH));
                            n_len = r_len + LEN_W'(1);
                        end else begin
                            n_len    = '0;
                            do_fresh = 1'b1;
                        end
                    end
                    ckl_pkg::M_QUOTE: begin
                        if (r_esc) begin
                            n_esc = 1'b0;
                        end else if (c == 8'h5C) begin
                            n_esc = 1'b1;
                        end else if (c == (r_dq ? 8'h22 : 8'h27)) begin
                            n_mode = ckl_pkg::M_IDLE;
                        end
                    end
                    ckl_pkg::M_SLASH: begin
                        if (c == 8'h2F) begin
                            n_mode = ckl_pkg::M_LINE;
                        end else if (c == 8'h2A) begin
                            n_mode = ckl_pkg::M_BLOCK;
                        end else begin
                            do_fresh = 1'b1;
                        end
                    end
                    ckl_pkg::M_LINE: begin
                        if (c == 8'h0A) begin
                            n_mode = ckl_pkg::M_IDLE;
                        end
                    end
                    ckl_pkg::M_BLOCK: begin
                        if (c == 8'h2A) begin
                            n_mode = ckl_pkg::M_STAR;
                        end
                    end
                    ckl_pkg::M_STAR: begin
                        if (c == 8'h2F) begin
                            n_mode = ckl_pkg::M_IDLE;
                        end else if (c != 8'h2A) begin
                            n_mode = ckl_pkg::M_BLOCK;
                        end
                    end
                    default: begin
                        do_fresh = 1'b1;
                    end
                endcase
                if (do_fresh) begin
                    n_mode = ckl_pkg::M_IDLE;
                    if (is_space(c)) begin
                        n_mode = ckl_pkg::M_IDLE;
                    end else if (c == 8'h22 || c == 8'h27) begin
                        n_mode = ckl_pkg::M_QUOTE;
                        n_dq   = (c == 8'h22);
                        n_esc  = 1'b0;
                    end else if (c == 8'h2F) begin
                        n_mode = ckl_pkg::M_SLASH;
                    end else if (is_alpha(c) || c == 8'h5F) begin
                        n_mode = ckl_pkg::M_WORD;
                        pf_we  = 1'b1;
                        pf_idx = '0;
                        n_len  = LEN_W'(1);
                    end
                end
            end
        end
    end

    // Commands toward the counter back end.
    always_comb begin
        finishing   = (r_mode == ckl_pkg::M_WORD) && (i_item.end_of_stream || !word_go_on);
        o_cmd.has_hit = finishing && any_hit;
        o_cmd.hit_idx = hit_idx;
        o_cmd.dump    = i_item.end_of_stream;
        o_cmd_valid   = i_accept && (o_cmd.has_hit || o_cmd.dump);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ckl_pkg::M_IDLE;
            r_dq   <= 1'b0;
            r_esc  <= 1'b0;
            r_len  <= '0;
        end else begin
            r_mode <= n_mode;
            r_dq   <= n_dq;
            r_esc  <= n_esc;
            r_len  <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pf_we) begin
            r_prefix[pf_idx] <= c;
        end
    end

endmodule

>>> hdl/ckl_cmd_fifo.sv
// Short command queue between the lexer front end and the counter back end.
module ckl_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ckl_pkg::t_cmd i_data,
    output logic          o_full,
    output logic          o_empty,
    input  logic          i_pop,
    output ckl_pkg::t_cmd o_data
);

    ckl_pkg::t_cmd                  r_mem [ckl_pkg::CMD_DEPTH];
    logic [ckl_pkg::CMD_PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [ckl_pkg::CMD_PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [ckl_pkg::CMD_PTR_W:0]    r_count, n_count;
    logic                           do_push;
    logic                           do_pop;

    assign o_full  = (r_count == (ckl_pkg::CMD_PTR_W + 1)'(ckl_pkg::CMD_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> hdl/ckl_back.sv
// Counter back end: keyword counters, hit reports, end-of-stream dump and result register.
module ckl_back #(
    parameter int COUNT_WIDTH = ckl_pkg::COUNT_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  ckl_pkg::t_cmd    i_cmd,
    output logic             o_cmd_pop,
    output logic             o_valid,
    input  logic             i_pop,
    output ckl_pkg::t_result o_result
);

    ckl_pkg::t_back_state         r_state, n_state;
    logic [COUNT_WIDTH-1:0]       r_count [ckl_pkg::KW_NUM];
    logic [ckl_pkg::KW_IDX_W-1:0] r_k, n_k;
    logic                         r_out_valid;
    ckl_pkg::t_result             r_out, out_data;

    logic                         out_free;
    logic                         out_load;
    logic                         cnt_we;
    logic [COUNT_WIDTH-1:0]       cur_cnt;
    logic [COUNT_WIDTH-1:0]       inc_cnt;
    logic                         scan_nz;
    logic [ckl_pkg::KW_NUM-1:0]   nz;
    logic [ckl_pkg::KW_NUM-1:0]   hi_mask;
    logic                         any_above;
    logic                         idle_take;
    logic                         scan_step;

    assign out_free = !r_out_valid || i_pop;
    assign cur_cnt  = r_count[i_cmd.hit_idx];
    assign inc_cnt  = (cur_cnt == {COUNT_WIDTH{1'b1}}) ? cur_cnt : cur_cnt + 1'b1;
    assign scan_nz  = (r_count[r_k] != '0);

    always_comb begin
        for (int k = 0; k < ckl_pkg::KW_NUM; k++) begin
            nz[k] = (r_count[k] != '0);
        end
        hi_mask   = ~((ckl_pkg::KW_NUM'(1) << (32'(r_k) + 1)) - ckl_pkg::KW_NUM'(1));
        any_above = |(nz & hi_mask);
    end

    assign idle_take = (r_state == ckl_pkg::B_IDLE) && i_cmd_valid
                       && (!i_cmd.has_hit || out_free);
    assign scan_step = (r_state == ckl_pkg::B_SCAN) && (!scan_nz || out_free);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ckl_pkg::B_IDLE: begin
                if (idle_take && i_cmd.dump) begin
                    n_state = ckl_pkg::B_SCAN;
                end
            end
            ckl_pkg::B_SCAN: begin
                if (scan_step && r_k == ckl_pkg::KW_IDX_W'(ckl_pkg::KW_ACTIVE - 1)) begin
                    n_state = ckl_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = ckl_pkg::B_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd_pop = 1'b0;
        cnt_we    = 1'b0;
        out_load  = 1'b0;
        out_data  = '0;
        n_k       = r_k;
        case (r_state)
            ckl_pkg::B_IDLE: begin
                if (idle_take) begin
                    o_cmd_pop = 1'b1;
                    n_k       = '0;
                    if (i_cmd.has_hit) begin
                        cnt_we                 = 1'b1;
                        out_load               = 1'b1;
                        out_data.report_kind   = ckl_pkg::REPORT_HIT;
                        out_data.keyword_index = i_cmd.hit_idx;
                        out_data.keyword_count = ckl_pkg::REPORT_W'(inc_cnt);
                        out_data.last_of_run   = !i_cmd.dump;
                    end
                end
            end
            ckl_pkg::B_SCAN: begin
                if (scan_step) begin
                    n_k = r_k + 1'b1;
                    if (scan_nz) begin
                        out_load               = 1'b1;
                        out_data.report_kind   = ckl_pkg::REPORT_DUMP;
                        out_data.keyword_index = r_k;
                        out_data.keyword_count = ckl_pkg::REPORT_W'(r_count[r_k]);
                        out_data.last_of_run   = !any_above;
                    end
                end
            end
            default: begin
                n_k = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ckl_pkg::B_IDLE;
            r_k         <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < ckl_pkg::KW_NUM; k++) begin
                r_count[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (cnt_we) begin
                r_count[i_cmd.hit_idx] <= inc_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= out_data;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

>>> hdl/ckl_checker.sv
// Port-level checks of the C keyword counter and their binding to the top level.
module ckl_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             empty,
    input logic             pop,
    input ckl_pkg::t_result o_result
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("results present right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("stalled result changed");

    a_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.keyword_index < ckl_pkg::KW_ACTIVE))
        else $error("keyword index out of table");

    a_hit_then_dump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_result.report_kind == ckl_pkg::REPORT_HIT
         && !o_result.last_of_run)
        |=> (empty || o_result.report_kind == ckl_pkg::REPORT_DUMP))
        else $error("hit report not closing its item was not followed by a dump");

    a_dump_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_result.report_kind == ckl_pkg::REPORT_DUMP
         && !o_result.last_of_run)
        |=> (empty || (o_result.report_kind == ckl_pkg::REPORT_DUMP
             && o_result.keyword_index > $past(o_result.keyword_index))))
        else $error("dump entries out of table order");

endmodule

bind c_keyword_lexer_counter ckl_checker u_ckl_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .empty     (empty),
    .pop       (pop),
    .o_result  (o_result)
);
